// File: rtl/fsdct_pkg.sv
// ----------------------------------------------------------------------------
// fsdct_pkg
// Shared types, codes and helpers for the float-selected dual cycle timer.
// ----------------------------------------------------------------------------
package fsdct_pkg;

	// Time base
	localparam int TICK_MS      = 100;
	localparam int MS_PER_S     = 1000;
	localparam int FRAC_W       = $clog2(MS_PER_S + 1);
	localparam int ELAPSED_W    = 17;    // saturates above any debounce setting
	localparam int SEC_W        = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [FRAC_W-1:0] FRAC_FULL = FRAC_W'(MS_PER_S);
	localparam logic [FRAC_W-1:0] FRAC_TICK = FRAC_W'(TICK_MS);
	localparam logic [FRAC_W-1:0] FRAC_WRAP = FRAC_W'(MS_PER_S - TICK_MS);

	// Item modes
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	// Float states
	localparam logic [1:0] FL_UNKNOWN = 2'd0;
	localparam logic [1:0] FL_OFF     = 2'd1;
	localparam logic [1:0] FL_ON      = 2'd2;

	// Channels
	localparam logic [1:0] CH_NONE = 2'd0;
	localparam logic [1:0] CH_ONE  = 2'd1;
	localparam logic [1:0] CH_TWO  = 2'd2;

	// Phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ON   = 2'd1;
	localparam logic [1:0] PH_OFF  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLOAT_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELAY_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CH1_ON      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CH1_OFF     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CH2_ON      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CH2_OFF     = 3'd7;

	typedef struct packed {
		logic              float_inverted;
		logic [1:0]        relay_active_low;
		logic [1:0]        start_in_off;
		logic [15:0]       settle_ms;
		logic [SEC_W-1:0]  ch1_on_sec;
		logic [SEC_W-1:0]  ch1_off_sec;
		logic [SEC_W-1:0]  ch2_on_sec;
		logic [SEC_W-1:0]  ch2_off_sec;
	} cfg_t;

	typedef struct packed {
		logic [1:0] state;     // confirmed float state after this item
		logic       changed;   // confirmed state changed on this tick
	} flt_t;

	typedef struct packed {
		logic             relay_one_pin;
		logic             relay_two_pin;
		logic             relay_one_on;
		logic             relay_two_on;
		logic             is_running;
		logic             is_stabilizing;
		logic [1:0]       float_status;
		logic [1:0]       channel;
		logic [1:0]       timer_phase;
		logic [SEC_W-1:0] remaining_sec;
		logic [SEC_W-1:0] phase_length_sec;
	} res_t;

	function automatic logic [SEC_W-1:0] phase_dur(cfg_t c, logic [1:0] ch, logic [1:0] ph);
		logic [SEC_W-1:0] d;
		d = '0;
		if (ch == CH_ONE) begin
			d = (ph == PH_ON) ? c.ch1_on_sec : c.ch1_off_sec;
		end else if (ch == CH_TWO) begin
			d = (ph == PH_ON) ? c.ch2_on_sec : c.ch2_off_sec;
		end
		return d;
	endfunction

	function automatic logic [1:0] start_phase(cfg_t c, logic [1:0] ch);
		logic off;
		off = (ch == CH_TWO) ? c.start_in_off[1] : c.start_in_off[0];
		return off ? PH_OFF : PH_ON;
	endfunction

	function automatic logic [1:0] chan_of(logic [1:0] fl);
		logic [1:0] ch;
		ch = CH_NONE;
		if (fl == FL_ON) begin
			ch = CH_TWO;
		end else if (fl == FL_OFF) begin
			ch = CH_ONE;
		end
		return ch;
	endfunction

endpackage

// File: rtl/float_selected_dual_cycle_timer_core.sv
// ----------------------------------------------------------------------------
// float_selected_dual_cycle_timer_core
// Debounced float switch selecting one of two cyclic on/off relay timers.
// ----------------------------------------------------------------------------
// Output: the result of an item is loaded into the output register at the
//   edge that accepts the item and is offered from that edge on.
// Throughput: one item per cycle; the output register is reloaded on the same
//   edge that hands its item off, so in_ready only drops while a result stalls.
// Reset: arst_n clears all timer, debounce and handshake state at once and
//   loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module float_selected_dual_cycle_timer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [fsdct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsdct_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         mode,
	input  logic                               float_level,
	// result items
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               relay_one_pin,
	output logic                               relay_two_pin,
	output logic                               relay_one_on,
	output logic                               relay_two_on,
	output logic                               is_running,
	output logic                               is_stabilizing,
	output logic [1:0]                         float_status,
	output logic [1:0]                         channel,
	output logic [1:0]                         timer_phase,
	output logic [fsdct_pkg::SEC_W-1:0]        remaining_sec,
	output logic [fsdct_pkg::SEC_W-1:0]        phase_length_sec
);
	import fsdct_pkg::*;

	cfg_t cfg;
	flt_t flt;
	res_t res_nx;
	res_t res_q;
	logic out_valid_q;
	logic fire;

	// Accept whenever the output register is empty or emptying this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	fsdct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Debounce runs on every tick, running or not.
	fsdct_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (fire && (mode == MODE_TICK)),
		.float_level (float_level),
		.cfg         (cfg),
		.flt         (flt)
	);

	// Control and timer state; res_nx is the status after this item.
	fsdct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.mode   (mode),
		.cfg    (cfg),
		.flt    (flt),
		.res    (res_nx)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nx;
		end
	end

	assign out_valid        = out_valid_q;
	assign relay_one_pin    = res_q.relay_one_pin;
	assign relay_two_pin    = res_q.relay_two_pin;
	assign relay_one_on     = res_q.relay_one_on;
	assign relay_two_on     = res_q.relay_two_on;
	assign is_running       = res_q.is_running;
	assign is_stabilizing   = res_q.is_stabilizing;
	assign float_status     = res_q.float_status;
	assign channel          = res_q.channel;
	assign timer_phase      = res_q.timer_phase;
	assign remaining_sec    = res_q.remaining_sec;
	assign phase_length_sec = res_q.phase_length_sec;

	// Only one relay can ever be energized.
	a_one_relay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(relay_one_on && relay_two_on))
		else $error("both relays energized");

	// Stabilizing is a sub-state of running.
	a_stab_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_stabilizing |-> is_running)
		else $error("stabilizing while stopped");

	// A stopped or stabilizing block drives no relay.
	a_relay_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!is_running || is_stabilizing) |-> !relay_one_on && !relay_two_on)
		else $error("relay energized while not timing");

	// An active phase always belongs to a selected channel.
	a_phase_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (timer_phase != PH_IDLE) |-> (channel != CH_NONE))
		else $error("phase active with no channel");

endmodule

// File: rtl/fsdct_cfg.sv
// ----------------------------------------------------------------------------
// fsdct_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module fsdct_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fsdct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsdct_pkg::CFG_DATA_W-1:0]   cfg_data,
	output fsdct_pkg::cfg_t                    cfg
);
	import fsdct_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.float_inverted   <= 1'b1;
			cfg_q.relay_active_low <= 2'd3;
			cfg_q.start_in_off     <= 2'd0;
			cfg_q.settle_ms        <= 16'd1000;
			cfg_q.ch1_on_sec       <= SEC_W'(60);
			cfg_q.ch1_off_sec      <= SEC_W'(60);
			cfg_q.ch2_on_sec       <= SEC_W'(60);
			cfg_q.ch2_off_sec      <= SEC_W'(60);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLOAT_LOW: cfg_q.float_inverted   <= cfg_data[0];
				REG_RELAY_LOW: cfg_q.relay_active_low <= cfg_data[1:0];
				REG_START_OFF: cfg_q.start_in_off     <= cfg_data[1:0];
				REG_DEBOUNCE:  cfg_q.settle_ms        <= cfg_data[15:0];
				REG_CH1_ON:    cfg_q.ch1_on_sec       <= cfg_data[SEC_W-1:0];
				REG_CH1_OFF:   cfg_q.ch1_off_sec      <= cfg_data[SEC_W-1:0];
				REG_CH2_ON:    cfg_q.ch2_on_sec       <= cfg_data[SEC_W-1:0];
				REG_CH2_OFF:   cfg_q.ch2_off_sec      <= cfg_data[SEC_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/fsdct_debounce.sv
// ----------------------------------------------------------------------------
// fsdct_debounce
// Time-based debounce of the raw float level into a confirmed float state.
// ----------------------------------------------------------------------------
module fsdct_debounce (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,         // a tick item is accepted
	input  logic              float_level,
	input  fsdct_pkg::cfg_t   cfg,
	output fsdct_pkg::flt_t   flt
);
	import fsdct_pkg::*;

	logic [1:0]           pending_q;
	logic [1:0]           confirmed_q;
	logic [ELAPSED_W-1:0] elapsed_q;     // ms the pending level has held

	logic [1:0]           raw;
	logic [ELAPSED_W:0]   sum;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic                 confirm;

	always_comb begin
		raw         = ((float_level == 1'b0) == cfg.float_inverted) ? FL_ON : FL_OFF;
		sum         = {1'b0, elapsed_q} + (ELAPSED_W+1)'(TICK_MS);
		elapsed_inc = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
		confirm     = (pending_q == raw) && (confirmed_q != raw)
		              && (elapsed_inc >= ELAPSED_W'(cfg.settle_ms));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= FL_UNKNOWN;
			confirmed_q <= FL_UNKNOWN;
			elapsed_q   <= '0;
		end else if (tick) begin
			if (pending_q != raw) begin
				pending_q <= raw;
				elapsed_q <= '0;
			end else begin
				elapsed_q <= elapsed_inc;
			end
			if (confirm) begin
				confirmed_q <= raw;
			end
		end
	end

	assign flt.state   = (tick && confirm) ? raw : confirmed_q;
	assign flt.changed = tick && confirm;

endmodule

// File: rtl/fsdct_ctrl.sv
// ----------------------------------------------------------------------------
// fsdct_ctrl
// Run/stabilize control, channel selection and the cyclic phase timer.
// ----------------------------------------------------------------------------
module fsdct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [1:0]        mode,
	input  fsdct_pkg::cfg_t   cfg,
	input  fsdct_pkg::flt_t   flt,
	output fsdct_pkg::res_t   res
);
	import fsdct_pkg::*;

	logic             run_q, stab_q, r1_q, r2_q;
	logic [1:0]       ch_q, ph_q;
	logic [SEC_W-1:0] secs_q, cnt_q;
	logic [FRAC_W-1:0] frac_q;   // ms left in the current second, 100..1000

	logic             run_n, stab_n, r1_n, r2_n;
	logic [1:0]       ch_n, ph_n;
	logic [SEC_W-1:0] secs_n, cnt_n;
	logic [FRAC_W-1:0] frac_n;

	logic             do_begin, do_enter, do_preview, do_recalc;
	logic [1:0]       enter_ph;
	logic             borrow, passed;
	logic [SEC_W-1:0] dur;

	always_comb begin
		run_n = run_q; stab_n = stab_q; r1_n = r1_q; r2_n = r2_q;
		ch_n = ch_q; ph_n = ph_q; secs_n = secs_q; cnt_n = cnt_q; frac_n = frac_q;
		do_begin = 1'b0; do_enter = 1'b0; do_preview = 1'b0; do_recalc = 1'b0;
		enter_ph = PH_ON;
		borrow   = (frac_q <= FRAC_TICK);
		passed   = (secs_q == '0) || (borrow && secs_q == SEC_W'(1));
		dur      = '0;

		if (fire) begin
			unique case (mode)
				MODE_TICK: begin
					if (!run_q) begin
						do_preview = 1'b1;
					end else if (stab_q) begin
						r1_n = 1'b0;
						r2_n = 1'b0;
						if (flt.state != FL_UNKNOWN) begin
							stab_n   = 1'b0;
							do_begin = 1'b1;
						end
					end else begin
						if (flt.changed) begin
							do_begin = 1'b1;
						end else if (ph_q != PH_IDLE) begin
							if (passed) begin
								do_enter = 1'b1;
								enter_ph = (ph_q == PH_ON) ? PH_OFF : PH_ON;
							end else if (borrow) begin
								secs_n = secs_q - SEC_W'(1);
								frac_n = frac_q + FRAC_WRAP;
							end else begin
								frac_n = frac_q - FRAC_TICK;
							end
						end
						do_recalc = 1'b1;
					end
				end
				MODE_START: begin
					if (!run_q) begin
						run_n  = 1'b1;
						stab_n = (flt.state == FL_UNKNOWN);
						r1_n   = 1'b0;
						r2_n   = 1'b0;
						if (flt.state != FL_UNKNOWN) begin
							do_begin = 1'b1;
						end else begin
							ch_n  = CH_NONE;
							ph_n  = PH_IDLE;
							cnt_n = '0;
						end
					end
				end
				MODE_STOP: begin
					run_n      = 1'b0;
					stab_n     = 1'b0;
					do_preview = 1'b1;
				end
				default: begin
					// status read
					if (run_q) begin
						do_recalc = 1'b1;
					end else begin
						do_preview = 1'b1;
					end
				end
			endcase
		end

		if (do_begin) begin
			r1_n = 1'b0;
			r2_n = 1'b0;
			ch_n = chan_of(flt.state);
			if (ch_n == CH_NONE) begin
				ph_n  = PH_IDLE;
				cnt_n = '0;
			end else begin
				do_enter = 1'b1;
				enter_ph = start_phase(cfg, ch_n);
			end
		end

		if (do_enter) begin
			dur    = phase_dur(cfg, ch_n, enter_ph);
			ph_n   = enter_ph;
			secs_n = dur;
			frac_n = FRAC_FULL;
			cnt_n  = dur;
			r1_n   = (enter_ph == PH_ON) && (ch_n == CH_ONE);
			r2_n   = (enter_ph == PH_ON) && (ch_n == CH_TWO);
		end

		if (do_preview) begin
			r1_n = 1'b0;
			r2_n = 1'b0;
			ch_n = chan_of(flt.state);
			if (ch_n == CH_NONE) begin
				ph_n  = PH_IDLE;
				cnt_n = '0;
			end else begin
				ph_n  = start_phase(cfg, ch_n);
				cnt_n = phase_dur(cfg, ch_n, ph_n);
			end
		end

		if (do_recalc) begin
			cnt_n = (ph_n == PH_IDLE) ? '0 : secs_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			stab_q <= 1'b0;
			r1_q   <= 1'b0;
			r2_q   <= 1'b0;
			ch_q   <= CH_NONE;
			ph_q   <= PH_IDLE;
			secs_q <= '0;
			frac_q <= FRAC_FULL;
			cnt_q  <= '0;
		end else if (fire) begin
			run_q  <= run_n;
			stab_q <= stab_n;
			r1_q   <= r1_n;
			r2_q   <= r2_n;
			ch_q   <= ch_n;
			ph_q   <= ph_n;
			secs_q <= secs_n;
			frac_q <= frac_n;
			cnt_q  <= cnt_n;
		end
	end

	always_comb begin
		res.relay_one_pin    = r1_n ^ cfg.relay_active_low[0];
		res.relay_two_pin    = r2_n ^ cfg.relay_active_low[1];
		res.relay_one_on     = r1_n;
		res.relay_two_on     = r2_n;
		res.is_running       = run_n;
		res.is_stabilizing   = stab_n;
		res.float_status     = flt.state;
		res.channel          = ch_n;
		res.timer_phase      = ph_n;
		res.remaining_sec    = cnt_n;
		res.phase_length_sec = (ch_n != CH_NONE && ph_n != PH_IDLE)
		                       ? phase_dur(cfg, ch_n, ph_n) : '0;
	end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the float-selected dual cycle timer. A shadow model
// of the debounce, channel select and on/off timers predicts one status item
// per accepted input item; the monitor compares every field in order.
// ----------------------------------------------------------------------------
module testbench;
	import fsdct_pkg::*;

	localparam int TIME_W = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	// mode 3 is not a named code of the block; it behaves as a status read
	localparam logic [1:0] MODE_STATUS = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic       level;
	} timer_cmd_t;

	// ------------------------------------------------------------------------
	// DUT signals; every input starts at a known level
	// ------------------------------------------------------------------------
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            mode = MODE_TICK;
	logic                  float_level = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  relay_one_pin;
	logic                  relay_two_pin;
	logic                  relay_one_on;
	logic                  relay_two_on;
	logic                  is_running;
	logic                  is_stabilizing;
	logic [1:0]            float_status;
	logic [1:0]            channel;
	logic [1:0]            timer_phase;
	logic [SEC_W-1:0]      remaining_sec;
	logic [SEC_W-1:0]      phase_length_sec;

	float_selected_dual_cycle_timer_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.float_level      (float_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.relay_one_pin    (relay_one_pin),
		.relay_two_pin    (relay_two_pin),
		.relay_one_on     (relay_one_on),
		.relay_two_on     (relay_two_on),
		.is_running       (is_running),
		.is_stabilizing   (is_stabilizing),
		.float_status     (float_status),
		.channel          (channel),
		.timer_phase      (timer_phase),
		.remaining_sec    (remaining_sec),
		.phase_length_sec (phase_length_sec)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Bench bookkeeping
	// ------------------------------------------------------------------------
	timer_cmd_t cmd_backlog[$];      // items waiting for the driver
	res_t       status_expected[$];  // predicted status items, oldest first
	timer_cmd_t next_cmd;
	int         queued_count = 0;
	int         accepted_count = 0;
	int         fail_count = 0;
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	logic       in_taken = 1'b0;
	// float level generator for the random part
	logic       lvl_now = 1'b0;
	int         run_left = 0;

	// ------------------------------------------------------------------------
	// Shadow of the block: registers and timer state
	// ------------------------------------------------------------------------
	cfg_t              shadow_cfg;
	logic [TIME_W-1:0] now_ms;
	logic [1:0]        pend_fl;
	logic [TIME_W-1:0] pend_since;
	logic [1:0]        conf_fl;
	logic              run_f;
	logic              stab_f;
	logic [1:0]        act_ch;
	logic [1:0]        cur_ph;
	logic [TIME_W-1:0] due_ms;
	logic [SEC_W-1:0]  count_sec;
	logic              r1_en;
	logic              r2_en;

	function automatic logic [SEC_W-1:0] dur_of(logic [1:0] ch, logic [1:0] ph);
		logic [SEC_W-1:0] d;
		d = '0;
		if (ch == CH_ONE) begin
			d = (ph == PH_ON) ? shadow_cfg.ch1_on_sec : shadow_cfg.ch1_off_sec;
		end else if (ch == CH_TWO) begin
			d = (ph == PH_ON) ? shadow_cfg.ch2_on_sec : shadow_cfg.ch2_off_sec;
		end
		return d;
	endfunction

	function automatic logic [1:0] first_phase(logic [1:0] ch);
		logic off_bit;
		off_bit = (ch == CH_TWO) ? shadow_cfg.start_in_off[1] : shadow_cfg.start_in_off[0];
		return off_bit ? PH_OFF : PH_ON;
	endfunction

	function automatic logic [1:0] float_chan(logic [1:0] fl);
		logic [1:0] ch;
		ch = CH_NONE;
		if (fl == FL_ON) begin
			ch = CH_TWO;
		end else if (fl == FL_OFF) begin
			ch = CH_ONE;
		end
		return ch;
	endfunction

	// deadline reached: wrapped distance is zero or lies in the upper half
	function automatic logic due_reached(logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] d;
		d = due_ms - t;
		return (d == '0) || d[TIME_W-1];
	endfunction

	function automatic logic [SEC_W-1:0] secs_to_go(logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] d;
		logic [TIME_W:0]   s;
		if (!run_f || cur_ph == PH_IDLE || due_reached(t)) begin
			return '0;
		end
		d = due_ms - t;
		s = ({1'b0, d} + (TIME_W + 1)'(MS_PER_S - 1)) / (TIME_W + 1)'(MS_PER_S);
		if (s > (TIME_W + 1)'(16'hFFFF)) begin
			return 16'hFFFF;
		end
		return s[SEC_W-1:0];
	endfunction

	task automatic enter_phase(logic [1:0] ph, logic [TIME_W-1:0] t);
		logic [SEC_W-1:0] d;
		r1_en = 1'b0;
		r2_en = 1'b0;
		if (act_ch == CH_NONE) begin
			cur_ph = PH_IDLE;
			count_sec = '0;
			return;
		end
		d = dur_of(act_ch, ph);
		cur_ph = ph;
		due_ms = t + TIME_W'(d) * TIME_W'(MS_PER_S);
		count_sec = d;
		if (ph == PH_ON) begin
			if (act_ch == CH_ONE) r1_en = 1'b1;
			else r2_en = 1'b1;
		end
	endtask

	// stopped view: start phase of the selected channel at full length
	task automatic show_preview();
		act_ch = float_chan(conf_fl);
		r1_en = 1'b0;
		r2_en = 1'b0;
		due_ms = '0;
		if (act_ch == CH_NONE) begin
			cur_ph = PH_IDLE;
			count_sec = '0;
		end else begin
			cur_ph = first_phase(act_ch);
			count_sec = dur_of(act_ch, cur_ph);
		end
	endtask

	task automatic begin_channel(logic [TIME_W-1:0] t);
		r1_en = 1'b0;
		r2_en = 1'b0;
		act_ch = float_chan(conf_fl);
		if (act_ch == CH_NONE) begin
			cur_ph = PH_IDLE;
			count_sec = '0;
			due_ms = '0;
		end else begin
			enter_phase(first_phase(act_ch), t);
		end
	endtask

	task automatic run_tick(logic level);
		logic [1:0] raw;
		logic       changed;
		logic       active;
		active = shadow_cfg.float_inverted ? (level == 1'b0) : (level == 1'b1);
		now_ms = now_ms + TIME_W'(TICK_MS);
		raw = active ? FL_ON : FL_OFF;
		// debounce: a level must hold for settle_ms before it is confirmed
		changed = 1'b0;
		if (pend_fl != raw) begin
			pend_fl = raw;
			pend_since = now_ms;
		end else if (conf_fl != raw &&
				(now_ms - pend_since) >= TIME_W'(shadow_cfg.settle_ms)) begin
			conf_fl = raw;
			changed = 1'b1;
		end
		if (!run_f) begin
			show_preview();
			return;
		end
		if (stab_f) begin
			r1_en = 1'b0;
			r2_en = 1'b0;
			if (conf_fl != FL_UNKNOWN) begin
				stab_f = 1'b0;
				begin_channel(now_ms);
			end
			return;
		end
		if (changed) begin
			begin_channel(now_ms);
		end else if (cur_ph != PH_IDLE && due_reached(now_ms)) begin
			enter_phase((cur_ph == PH_ON) ? PH_OFF : PH_ON, now_ms);
		end
		count_sec = secs_to_go(now_ms);
	endtask

	// one accepted item in, one predicted status item out
	task automatic predict_status(timer_cmd_t c);
		res_t e;
		case (c.mode)
			MODE_TICK: begin
				run_tick(c.level);
			end
			MODE_START: begin
				if (!run_f) begin
					run_f = 1'b1;
					stab_f = (conf_fl == FL_UNKNOWN);
					due_ms = '0;
					r1_en = 1'b0;
					r2_en = 1'b0;
					if (!stab_f) begin
						begin_channel(now_ms);
					end else begin
						act_ch = CH_NONE;
						cur_ph = PH_IDLE;
						count_sec = '0;
					end
				end
			end
			MODE_STOP: begin
				run_f = 1'b0;
				stab_f = 1'b0;
				show_preview();
			end
			default: begin
				if (run_f) count_sec = secs_to_go(now_ms);
				else show_preview();
			end
		endcase
		e.relay_one_pin    = r1_en ^ shadow_cfg.relay_active_low[0];
		e.relay_two_pin    = r2_en ^ shadow_cfg.relay_active_low[1];
		e.relay_one_on     = r1_en;
		e.relay_two_on     = r2_en;
		e.is_running       = run_f;
		e.is_stabilizing   = stab_f;
		e.float_status     = conf_fl;
		e.channel          = act_ch;
		e.timer_phase      = cur_ph;
		e.remaining_sec    = count_sec;
		e.phase_length_sec = (act_ch != CH_NONE && cur_ph != PH_IDLE) ?
			dur_of(act_ch, cur_ph) : '0;
		status_expected.push_back(e);
	endtask

	// ------------------------------------------------------------------------
	// Input side: acceptance and prediction at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			predict_status('{mode: mode, level: float_level});
			accepted_count <= accepted_count + 1;
		end
	end

	// Driver: holds an offered item until taken, then offers the next one
	// unless the sender idles this cycle. The receiver's stalls are drawn here
	// as well so both sides move on the falling edge only.
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			// item still offered; payload stays put
		end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			next_cmd = cmd_backlog.pop_front();
			in_valid <= 1'b1;
			mode <= next_cmd.mode;
			float_level <= next_cmd.level;
		end else begin
			// idle: payload is junk while valid is low
			in_valid <= 1'b0;
			mode <= 2'($urandom);
			float_level <= 1'($urandom);
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------------
	// Monitor: each result item against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{relay_one_pin, relay_two_pin, relay_one_on, relay_two_on,
				is_running, is_stabilizing, float_status, channel, timer_phase,
				remaining_sec, phase_length_sec};
			if (status_expected.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("error: result item with nothing expected at cycle %0d",
						cycle_count);
			end else begin
				want = status_expected.pop_front();
				if (got !== want) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("error: mismatch at cycle %0d", cycle_count);
						$display("  exp pins=%b%b on=%b%b run=%b stab=%b fl=%0d ch=%0d ph=%0d rem=%0d len=%0d",
							want.relay_one_pin, want.relay_two_pin, want.relay_one_on,
							want.relay_two_on, want.is_running, want.is_stabilizing,
							want.float_status, want.channel, want.timer_phase,
							want.remaining_sec, want.phase_length_sec);
						$display("  got pins=%b%b on=%b%b run=%b stab=%b fl=%0d ch=%0d ph=%0d rem=%0d len=%0d",
							got.relay_one_pin, got.relay_two_pin, got.relay_one_on,
							got.relay_two_on, got.is_running, got.is_stabilizing,
							got.float_status, got.channel, got.timer_phase,
							got.remaining_sec, got.phase_length_sec);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL float_selected_dual_cycle_timer_core");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_cmd(logic [1:0] m, logic lv);
		cmd_backlog.push_back('{mode: m, level: lv});
		queued_count++;
	endtask

	// register write on the next falling edge; shadow follows with the same
	// masking the block applies
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FLOAT_LOW: shadow_cfg.float_inverted = val[0];
			REG_RELAY_LOW: shadow_cfg.relay_active_low = val[1:0];
			REG_START_OFF: shadow_cfg.start_in_off = val[1:0];
			REG_DEBOUNCE:  shadow_cfg.settle_ms = val;
			REG_CH1_ON:    shadow_cfg.ch1_on_sec = val;
			REG_CH1_OFF:   shadow_cfg.ch1_off_sec = val;
			REG_CH2_ON:    shadow_cfg.ch2_on_sec = val;
			default:       shadow_cfg.ch2_off_sec = val;
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every queued item is taken and its result checked
	task automatic drain();
		while (accepted_count != queued_count || status_expected.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [15:0] pick_secs();
		int r;
		r = $urandom_range(99);
		if (r < 4) return 16'd0;
		if (r < 7) return 16'hFFFF;
		if (r < 12) return 16'($urandom_range(5, 30));
		return 16'($urandom_range(1, 4));
	endfunction

	function automatic logic [15:0] pick_debounce();
		int r;
		r = $urandom_range(99);
		if (r < 8) return 16'd0;
		if (r < 11) return 16'hFFFF;
		if (r < 20) return 16'($urandom_range(1, 1500));
		return 16'($urandom_range(0, 450));
	endfunction

	// narrow registers mostly get in-range data, sometimes junk above it
	function automatic logic [15:0] pick_narrow(int hi);
		if ($urandom_range(3) == 0) return 16'($urandom);
		return 16'($urandom_range(0, hi));
	endfunction

	// kind 0: every register at its top, kind 1: all zero, else random
	task automatic apply_setting(int kind);
		if (kind == 0) begin
			write_reg(REG_FLOAT_LOW, 16'd1);
			write_reg(REG_RELAY_LOW, 16'd3);
			write_reg(REG_START_OFF, 16'd3);
			write_reg(REG_DEBOUNCE, 16'hFFFF);
			write_reg(REG_CH1_ON, 16'hFFFF);
			write_reg(REG_CH1_OFF, 16'hFFFF);
			write_reg(REG_CH2_ON, 16'hFFFF);
			write_reg(REG_CH2_OFF, 16'hFFFF);
		end else if (kind == 1) begin
			write_reg(REG_FLOAT_LOW, 16'd0);
			write_reg(REG_RELAY_LOW, 16'd0);
			write_reg(REG_START_OFF, 16'd0);
			write_reg(REG_DEBOUNCE, 16'd0);
			write_reg(REG_CH1_ON, 16'd0);
			write_reg(REG_CH1_OFF, 16'd0);
			write_reg(REG_CH2_ON, 16'd0);
			write_reg(REG_CH2_OFF, 16'd0);
		end else begin
			write_reg(REG_FLOAT_LOW, pick_narrow(1));
			write_reg(REG_RELAY_LOW, pick_narrow(3));
			write_reg(REG_START_OFF, pick_narrow(3));
			write_reg(REG_DEBOUNCE, pick_debounce());
			write_reg(REG_CH1_ON, pick_secs());
			write_reg(REG_CH1_OFF, pick_secs());
			write_reg(REG_CH2_ON, pick_secs());
			write_reg(REG_CH2_OFF, pick_secs());
		end
		end_writes();
	endtask

	// Mostly ticks whose level holds in runs long enough to get through the
	// debounce, with short glitches, and starts/stops/status reads mixed in.
	task automatic queue_random(int n);
		int         r;
		logic [1:0] m;
		logic       lv;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			lv = 1'($urandom);
			if (r < 6) begin
				m = MODE_START;
			end else if (r < 9) begin
				m = MODE_STOP;
			end else if (r < 11) begin
				m = MODE_STATUS;
			end else begin
				m = MODE_TICK;
				if (run_left == 0) begin
					lvl_now = 1'($urandom);
					run_left = $urandom_range(1, 25);
				end
				run_left--;
				lv = ($urandom_range(99) < 4) ? ~lvl_now : lvl_now;
			end
			queue_cmd(m, lv);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		// shadow starts at the reset values of the block
		shadow_cfg = '{float_inverted: 1'b1, relay_active_low: 2'd3,
			start_in_off: 2'd0, settle_ms: 16'd1000, ch1_on_sec: 16'd60,
			ch1_off_sec: 16'd60, ch2_on_sec: 16'd60, ch2_off_sec: 16'd60};
		now_ms = '0;
		pend_fl = FL_UNKNOWN;
		pend_since = '0;
		conf_fl = FL_UNKNOWN;
		run_f = 1'b0;
		stab_f = 1'b0;
		act_ch = CH_NONE;
		cur_ph = PH_IDLE;
		due_ms = '0;
		count_sec = '0;
		r1_en = 1'b0;
		r2_en = 1'b0;

		send_idle_pct = 28;
		recv_idle_pct = 45;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed, default registers: status read and stop while stopped,
		// start with no confirmed float (stabilizing), then stop again
		queue_cmd(MODE_STATUS, 1'b0);
		queue_cmd(MODE_STOP, 1'b1);
		queue_cmd(MODE_START, 1'b0);
		queue_cmd(MODE_TICK, 1'b0);
		queue_cmd(MODE_TICK, 1'b1);
		queue_cmd(MODE_STOP, 1'b0);
		drain();

		// directed, zero debounce and zero-length phases, active-high pins
		write_reg(REG_FLOAT_LOW, 16'd0);
		write_reg(REG_RELAY_LOW, 16'd0);
		write_reg(REG_START_OFF, 16'd2);
		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_CH1_ON, 16'd0);
		write_reg(REG_CH1_OFF, 16'd1);
		write_reg(REG_CH2_ON, 16'd2);
		write_reg(REG_CH2_OFF, 16'd0);
		end_writes();
		queue_cmd(MODE_TICK, 1'b1);
		queue_cmd(MODE_TICK, 1'b1);   // second equal reading confirms
		queue_cmd(MODE_START, 1'b0);
		queue_cmd(MODE_START, 1'b1);  // already running: no effect
		queue_cmd(MODE_TICK, 1'b1);   // zero-length off phase ends
		queue_cmd(MODE_STATUS, 1'b0);
		queue_cmd(MODE_TICK, 1'b0);
		queue_cmd(MODE_TICK, 1'b0);   // float change restarts on channel one
		queue_cmd(MODE_TICK, 1'b0);
		queue_cmd(MODE_TICK, 1'b0);
		queue_cmd(MODE_TICK, 1'b1);
		queue_cmd(MODE_STOP, 1'b0);
		queue_cmd(MODE_STATUS, 1'b1);
		drain();

		// random part: twelve settings, extremes first, idling schedule moves
		// from sender-light to receiver-light to none
		for (int ph = 0; ph < 12; ph++) begin
			if (ph < 4) begin
				send_idle_pct = 28;
				recv_idle_pct = 45;
			end else if (ph < 8) begin
				send_idle_pct = 45;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			apply_setting(ph);
			queue_random(80);
			drain();
		end

		// settle: anything arriving now is an unexpected result
		repeat (10) @(negedge clk);
		if (fail_count == 0 && status_expected.size() == 0) begin
			$display("PASS float_selected_dual_cycle_timer_core");
		end else begin
			$display("FAIL float_selected_dual_cycle_timer_core");
		end
		$finish;
	end

endmodule
